FILE: sv/ubrb_pkg.sv
// ubrb_pkg: shared types, codes and defaults for the UART byte ring buffers.
// Used by ubrb_front, ubrb_back and uart_byte_ring_buffers; no dependencies.

package ubrb_pkg;

    // Default ring depths (any value from 2 to 4096 is supported)
    localparam int RX_DEPTH_DEF = 128;
    localparam int TX_DEPTH_DEF = 128;

    // Depth of the word queue between front and back
    localparam int CQ_DEPTH = 2;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // Command codes as they arrive on the port
    typedef enum logic [1:0] {
        OP_LINE_RX    = 2'd0,
        OP_LINE_READY = 2'd1,
        OP_HOST_WR    = 2'd2,
        OP_HOST_RD    = 2'd3
    } t_op;

    // out_kind codes
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_HOST = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RX_OVF   = 2'd1;
    localparam logic [1:0] ST_TX_FULL  = 2'd2;
    localparam logic [1:0] ST_RX_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } t_cmd_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic [1:0] status;
        logic       tx_empty;
        logic       tx_irq_enabled;
    } t_result;

    // Classified word as held in the queue
    typedef struct packed {
        t_op        op;
        logic       is_lf;
        logic [7:0] data_byte;
    } t_q_entry;

    // Queue head as seen by the back end
    typedef struct packed {
        logic     valid;
        t_q_entry entry;
    } t_q_head;

endpackage

FILE: sv/ubrb_front.sv
// ubrb_front: accepts command words, classifies them and queues them.
// Depends on ubrb_pkg.

module ubrb_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ubrb_pkg::t_cmd_word i_cmd,
    input  logic                i_pop,
    output ubrb_pkg::t_q_head   o_head
);

    localparam int QAW = (ubrb_pkg::CQ_DEPTH > 1) ? $clog2(ubrb_pkg::CQ_DEPTH) : 1;
    localparam int QCW = $clog2(ubrb_pkg::CQ_DEPTH + 1);

    ubrb_pkg::t_q_entry r_q [ubrb_pkg::CQ_DEPTH];
    logic [QAW-1:0]     r_wr, n_wr;
    logic [QAW-1:0]     r_rd, n_rd;
    logic [QCW-1:0]     r_count, n_count;
    ubrb_pkg::t_q_entry new_entry;
    logic               push;
    logic               pop;

    assign busy = (r_count == QCW'(ubrb_pkg::CQ_DEPTH));
    assign push = start && !busy;
    assign pop  = i_pop && (r_count != '0);

    always_comb begin
        new_entry.data_byte = i_cmd.data_byte;
        new_entry.is_lf     = (i_cmd.data_byte == ubrb_pkg::CH_LF);
        new_entry.op        = ubrb_pkg::t_op'(i_cmd.command);
    end

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (push) begin
            n_wr = (r_wr == QAW'(ubrb_pkg::CQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == QAW'(ubrb_pkg::CQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= new_entry;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_q[r_rd];

endmodule

FILE: sv/ubrb_back.sv
// ubrb_back: executes queued words against the receive and transmit rings.
// Holds both byte stores, all ring pointers and the irq flag. Depends on ubrb_pkg.

module ubrb_back #(
    parameter int RX_DEPTH = ubrb_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = ubrb_pkg::TX_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ubrb_pkg::t_q_head i_head,
    output logic              o_pop,
    output logic              o_done,
    output ubrb_pkg::t_result o_result
);

    localparam int RPW = $clog2(2 * RX_DEPTH);
    localparam int RAW = $clog2(RX_DEPTH);
    localparam int TPW = $clog2(2 * TX_DEPTH);
    localparam int TAW = $clog2(TX_DEPTH);
    localparam logic [RPW:0] RX_TWO_D = (RPW + 1)'(2 * RX_DEPTH);
    localparam logic [TPW:0] TX_TWO_D = (TPW + 1)'(2 * TX_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LF   = 4'b0010,
        S_TXRD = 4'b0100,
        S_RXRD = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [RPW-1:0] r_rx_wp, n_rx_wp, r_rx_rp, n_rx_rp;
    logic [TPW-1:0] r_tx_wp, n_tx_wp, r_tx_rp, n_tx_rp;
    logic           r_irq, n_irq;
    logic           r_done, n_done;
    ubrb_pkg::t_result r_result, n_result;

    logic [7:0] r_rx_mem [RX_DEPTH];
    logic [7:0] r_tx_mem [TX_DEPTH];
    logic [7:0] r_rx_rdata, r_tx_rdata;

    logic           rx_we, rx_re, tx_we, tx_re;
    logic [7:0]     tx_wdata;
    logic [RAW-1:0] rx_wslot, rx_rslot;
    logic [TAW-1:0] tx_wslot, tx_rslot;
    logic [RPW-1:0] rx_wp_nxt, rx_rp_nxt, rx_fill;
    logic [TPW-1:0] tx_wp_nxt, tx_rp_nxt, tx_fill;
    logic           rx_full, rx_empty, tx_empty_now, tx_no_room;

    // Pointer arithmetic: pointers run modulo twice the depth
    assign rx_wslot = (r_rx_wp >= RPW'(RX_DEPTH)) ? RAW'(r_rx_wp - RPW'(RX_DEPTH))
                                                   : RAW'(r_rx_wp);
    assign rx_rslot = (r_rx_rp >= RPW'(RX_DEPTH)) ? RAW'(r_rx_rp - RPW'(RX_DEPTH))
                                                   : RAW'(r_rx_rp);
    assign tx_wslot = (r_tx_wp >= TPW'(TX_DEPTH)) ? TAW'(r_tx_wp - TPW'(TX_DEPTH))
                                                   : TAW'(r_tx_wp);
    assign tx_rslot = (r_tx_rp >= TPW'(TX_DEPTH)) ? TAW'(r_tx_rp - TPW'(TX_DEPTH))
                                                   : TAW'(r_tx_rp);

    assign rx_wp_nxt = (r_rx_wp == RPW'(2 * RX_DEPTH - 1)) ? '0 : r_rx_wp + 1'b1;
    assign rx_rp_nxt = (r_rx_rp == RPW'(2 * RX_DEPTH - 1)) ? '0 : r_rx_rp + 1'b1;
    assign tx_wp_nxt = (r_tx_wp == TPW'(2 * TX_DEPTH - 1)) ? '0 : r_tx_wp + 1'b1;
    assign tx_rp_nxt = (r_tx_rp == TPW'(2 * TX_DEPTH - 1)) ? '0 : r_tx_rp + 1'b1;

    assign rx_fill = (r_rx_wp >= r_rx_rp) ? (r_rx_wp - r_rx_rp)
                   : RPW'({1'b0, r_rx_wp} + RX_TWO_D - {1'b0, r_rx_rp});
    assign tx_fill = (r_tx_wp >= r_tx_rp) ? (r_tx_wp - r_tx_rp)
                   : TPW'({1'b0, r_tx_wp} + TX_TWO_D - {1'b0, r_tx_rp});

    assign rx_full      = (rx_fill == RPW'(RX_DEPTH));
    assign rx_empty     = (r_rx_wp == r_rx_rp);
    assign tx_empty_now = (r_tx_wp == r_tx_rp);
    // newline goes in as CR LF and needs two free slots
    assign tx_no_room   = i_head.entry.is_lf ? (tx_fill > TPW'(TX_DEPTH - 2))
                                             : (tx_fill == TPW'(TX_DEPTH));

    always_comb begin
        n_state  = r_state;
        n_rx_wp  = r_rx_wp;
        n_rx_rp  = r_rx_rp;
        n_tx_wp  = r_tx_wp;
        n_tx_rp  = r_tx_rp;
        n_irq    = r_irq;
        n_done   = 1'b0;
        o_pop    = 1'b0;
        rx_we    = 1'b0;
        rx_re    = 1'b0;
        tx_we    = 1'b0;
        tx_re    = 1'b0;
        tx_wdata = i_head.entry.data_byte;
        n_result.out_byte = 8'd0;
        n_result.out_kind = ubrb_pkg::KIND_NONE;
        n_result.status   = ubrb_pkg::ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    unique case (i_head.entry.op)
                        ubrb_pkg::OP_LINE_RX: begin
                            n_done = 1'b1;
                            if (!rx_full) begin
                                rx_we   = 1'b1;
                                n_rx_wp = rx_wp_nxt;
                            end else begin
                                n_result.status = ubrb_pkg::ST_RX_OVF;
                            end
                        end
                        ubrb_pkg::OP_LINE_READY: begin
                            if (tx_empty_now) begin
                                n_irq  = 1'b0;
                                n_done = 1'b1;
                            end else begin
                                tx_re   = 1'b1;
                                n_tx_rp = tx_rp_nxt;
                                n_state = S_TXRD;
                            end
                        end
                        ubrb_pkg::OP_HOST_WR: begin
                            if (tx_no_room) begin
                                n_result.status = ubrb_pkg::ST_TX_FULL;
                                n_done = 1'b1;
                            end else if (i_head.entry.is_lf) begin
                                tx_we    = 1'b1;
                                tx_wdata = ubrb_pkg::CH_CR;
                                n_tx_wp  = tx_wp_nxt;
                                n_state  = S_LF;
                            end else begin
                                tx_we   = 1'b1;
                                n_tx_wp = tx_wp_nxt;
                                n_irq   = 1'b1;
                                n_done  = 1'b1;
                            end
                        end
                        default: begin
                            if (rx_empty) begin
                                n_result.status = ubrb_pkg::ST_RX_EMPTY;
                                n_done = 1'b1;
                            end else begin
                                rx_re   = 1'b1;
                                n_rx_rp = rx_rp_nxt;
                                n_state = S_RXRD;
                            end
                        end
                    endcase
                end
            end
            S_LF: begin
                tx_we    = 1'b1;
                tx_wdata = ubrb_pkg::CH_LF;
                n_tx_wp  = tx_wp_nxt;
                n_irq    = 1'b1;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            S_TXRD: begin
                n_result.out_byte = r_tx_rdata;
                n_result.out_kind = ubrb_pkg::KIND_LINE;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_RXRD: begin
                n_result.out_byte = r_rx_rdata;
                n_result.out_kind = ubrb_pkg::KIND_HOST;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_result.tx_empty       = (n_tx_wp == n_tx_rp);
        n_result.tx_irq_enabled = n_irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rx_wp <= '0;
            r_rx_rp <= '0;
            r_tx_wp <= '0;
            r_tx_rp <= '0;
            r_irq   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rx_wp <= n_rx_wp;
            r_rx_rp <= n_rx_rp;
            r_tx_wp <= n_tx_wp;
            r_tx_rp <= n_tx_rp;
            r_irq   <= n_irq;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    // Byte stores: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            r_rx_mem[rx_wslot] <= i_head.entry.data_byte;
        end
        if (rx_re) begin
            r_rx_rdata <= r_rx_mem[rx_rslot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tx_we) begin
            r_tx_mem[tx_wslot] <= tx_wdata;
        end
        if (tx_re) begin
            r_tx_rdata <= r_tx_mem[tx_rslot];
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_rx_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_fill <= RPW'(RX_DEPTH))
        else $error("rx ring fill level above depth");

    a_tx_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tx_fill <= TPW'(TX_DEPTH))
        else $error("tx ring fill level above depth");

    a_lf_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LF) |=> (o_done && o_result.tx_irq_enabled
                               && !o_result.tx_empty))
        else $error("newline write did not finish with a result");

    a_no_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.out_kind == ubrb_pkg::KIND_NONE))
            |-> (o_result.out_byte == 8'd0))
        else $error("byte reported without a byte kind");

    a_pop_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE) && i_head.valid)
        else $error("queue popped outside idle state");

endmodule

FILE: sv/uart_byte_ring_buffers.sv
// uart_byte_ring_buffers: top level of the UART receive/transmit byte rings.
// Instantiates ubrb_front (word queue) and ubrb_back (rings); uses ubrb_pkg.
//
//  Channel   Ports                       Handshake
//  -------   -------------------------   --------------------------------------
//  command   start, i_cmd, busy          word taken when start && !busy
//  result    o_done, o_result            one-cycle strobe, receiver never stalls
//
// Flow: an accepted word sits in a two-word queue; the back end pops it when
// idle, and its result strobe is registered. Line bytes, plain host writes,
// rejected writes and empty-ring cases finish from idle; host reads and line
// sends pass through a read state (registered read port of the byte store);
// a newline write passes through S_LF (CR and LF share one store write port).
// Reset: synchronous, clears pointers, irq flag, queue and strobe; the byte
// stores are not cleared and only ever read after a write.
// Stalls: busy is high while the queue holds two words.

module uart_byte_ring_buffers #(
    parameter int RX_DEPTH = ubrb_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = ubrb_pkg::TX_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ubrb_pkg::t_cmd_word i_cmd,
    output logic                o_done,
    output ubrb_pkg::t_result   o_result
);

    ubrb_pkg::t_q_head q_head;   // oldest queued word, valid when queue not empty
    logic              q_pop;    // back end takes the head word

    ubrb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    ubrb_back #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (q_head),
        .o_pop    (q_pop),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule
